@@ hw/rtl/assert_macros.svh @@
// Assertion helpers included by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, also during reset.
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ffa_pkg.sv @@
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int ARENA_UNITS = 4096;
  localparam int ADDR_W      = 12;
  localparam int SIZE_W      = 13;
  localparam int NEED_W      = 18;
  localparam int BYTES_W     = 20;
  localparam int UNIT_SHIFT  = 3;
  localparam int STEP_W      = 13;

  localparam logic [SIZE_W-1:0] GROWTH_RESET = 13'd1024;
  localparam logic [SIZE_W-1:0] ARENA_TOP    = 13'd4096;
  localparam logic [STEP_W-1:0] WALK_LIMIT   = 13'd4097;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_START,
    ST_A_FIRST,
    ST_W_EVAL,
    ST_SPLIT2,
    ST_G_START,
    ST_G_DIV,
    ST_G_WAIT,
    ST_R_START,
    ST_R_EVAL,
    ST_R_RDB,
    ST_R_RDNX,
    ST_R_WP
  } st_t;

  typedef struct packed {
    logic              start;
    logic [NEED_W-1:0] dividend;
    logic [NEED_W-1:0] divisor;
  } div_req_t;

endpackage

@@ hw/rtl/ffa_ram.sv @@
`timescale 1ns / 1ps
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ffa_div.sv @@
`timescale 1ns / 1ps
module ffa_div
  import ffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [NEED_W-1:0] quotient
);

  localparam logic [4:0] BITS = 5'(NEED_W);

  logic [NEED_W:0]   rem_r, rem_nxt;
  logic [NEED_W-1:0] quo_r, quo_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [NEED_W:0]   shifted;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[NEED_W-1:0], quo_r[NEED_W-1]};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      cnt_nxt = BITS;
    end else if (cnt_r != 5'd0) begin
      if (shifted >= {1'b0, req.divisor}) begin
        rem_nxt = shifted - {1'b0, req.divisor};
        quo_nxt = {quo_r[NEED_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NEED_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hw/rtl/first_fit_free_list_allocator.sv @@
`timescale 1ns / 1ps
// First-fit heap allocator over a 4096-unit arena of 8-byte units.
// Input: pulse start with in_kind, in_size_bytes and in_block_address while
// busy is low; the item transfers on that edge and busy rises next cycle,
// except for an ignored free, whose result follows at once with busy low.
// Allocate returns the payload unit on out_payload_address, or status 1 with
// address 0 when the heap cannot grow; free always returns address 0, status 0.
// Output: exactly one result per item, valid for the single cycle out_valid is
// high; the receiver cannot stall, so nothing is held back. busy is low again
// in that same cycle, so the next item may start at once.
// Time per item depends on the free list: allocate walks it node by node (with
// an extra step for a split), and each insertion walks it again. Each growth
// attempt runs the bit-serial divider, one attempt per divisor tried, after a
// setup step per growth. The header memories, each with one read and one write
// port, set the pace. cfg_wr_en loads the minimum growth size (units); the user
// must do so only while the block is idle, which the block itself does not
// enforce. After reset the block writes the sentinel header with busy high;
// the list is then empty, break at unit 1, minimum growth 1024.
module first_fit_free_list_allocator
  import ffa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [BYTES_W-1:0] in_size_bytes,
  input  logic [ADDR_W-1:0]  in_block_address,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_payload_address,
  output logic               out_status,
  input  logic               cfg_wr_en,
  input  logic [SIZE_W-1:0]  cfg_wr_data
);

`include "assert_macros.svh"

  st_t               state_r, state_nxt;
  logic [ADDR_W-1:0] rover_r, rover_nxt;
  logic [SIZE_W-1:0] brk_r, brk_nxt;
  logic [SIZE_W-1:0] gmin_r;
  logic              is_alloc_r, is_alloc_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt, prev_r, prev_nxt, b_r, b_nxt, nx_r, nx_nxt, q_r, q_nxt;
  logic [SIZE_W-1:0] sp_r, sp_nxt, sb_r, sb_nxt, sbn_r, sbn_nxt;
  logic [ADDR_W-1:0] nbn_r, nbn_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [NEED_W-1:0] add_r, add_nxt, div_r, div_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_status_r, out_status_nxt;

  logic [ADDR_W-1:0] raddr, waddr, nx_rd, next_wdata;
  logic [SIZE_W-1:0] sz_rd, size_wdata;
  logic              next_we, size_we;
  div_req_t          dreq;
  logic              div_done;
  logic [NEED_W-1:0] chunk;

  logic [NEED_W+2:0] need_calc;
  logic [STEP_W-1:0] steps_inc;
  logic              brk_hit;
  logic [NEED_W:0]   brk_sum;
  logic              grow_ok;
  logic [SIZE_W-1:0] sub_sz, b_end, p_end;
  logic [SIZE_W-1:0] free_hdr;

  ffa_ram #(.WIDTH(ADDR_W), .DEPTH(ARENA_UNITS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (waddr),
    .wdata (next_wdata),
    .raddr (raddr),
    .rdata (nx_rd)
  );

  ffa_ram #(.WIDTH(SIZE_W), .DEPTH(ARENA_UNITS)) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (waddr),
    .wdata (size_wdata),
    .raddr (raddr),
    .rdata (sz_rd)
  );

  ffa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (div_done),
    .quotient (chunk)
  );

  // derived values
  assign need_calc = NEED_W'((({1'b0, in_size_bytes} + 21'd7) >> UNIT_SHIFT)) + 21'd1;
  assign steps_inc = steps_r + 13'd1;
  assign free_hdr  = {1'b0, in_block_address} - 13'd1;
  assign brk_hit   = ((p_r < b_r) && (b_r < nx_rd)) ||
                     ((p_r >= nx_rd) && ((p_r < b_r) || (b_r < nx_rd)));
  assign brk_sum   = {6'd0, brk_r} + {1'b0, chunk};
  assign grow_ok   = (chunk != '0) && (brk_sum <= {6'd0, ARENA_TOP});
  assign sub_sz    = sz_rd - need_r[SIZE_W-1:0];
  assign b_end     = {1'b0, b_r} + sb_r;
  assign p_end     = {1'b0, p_r} + sp_r;

  // next state, memory access and result
  always_comb begin
    state_nxt      = state_r;
    rover_nxt      = rover_r;
    brk_nxt        = brk_r;
    is_alloc_nxt   = is_alloc_r;
    need_nxt       = need_r;
    p_nxt          = p_r;
    prev_nxt       = prev_r;
    b_nxt          = b_r;
    nx_nxt         = nx_r;
    q_nxt          = q_r;
    sp_nxt         = sp_r;
    sb_nxt         = sb_r;
    sbn_nxt        = sbn_r;
    nbn_nxt        = nbn_r;
    steps_nxt      = steps_r;
    add_nxt        = add_r;
    div_nxt        = div_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    raddr          = p_r;
    waddr          = p_r;
    next_wdata     = '0;
    size_wdata     = '0;
    next_we        = 1'b0;
    size_we        = 1'b0;
    dreq.start     = 1'b0;
    dreq.dividend  = add_r;
    dreq.divisor   = div_r;

    unique case (state_r)
      ST_INIT: begin
        waddr     = '0;
        next_we   = 1'b1;
        size_we   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          is_alloc_nxt = (in_kind == KIND_ALLOC);
          need_nxt     = need_calc[NEED_W-1:0];
          steps_nxt    = '0;
          if (in_kind == KIND_ALLOC) begin
            state_nxt = ST_A_START;
          end else if (in_block_address >= 12'd2 && free_hdr < brk_r) begin
            b_nxt     = free_hdr[ADDR_W-1:0];
            state_nxt = ST_R_START;
          end else begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = STATUS_OK;
          end
        end
      end
      ST_A_START: begin
        raddr     = rover_r;
        state_nxt = ST_A_FIRST;
      end
      ST_A_FIRST: begin
        prev_nxt  = rover_r;
        p_nxt     = nx_rd;
        raddr     = nx_rd;
        state_nxt = ST_W_EVAL;
      end
      ST_W_EVAL: begin
        if ({5'd0, sz_rd} >= need_r) begin
          rover_nxt = prev_r;
          if ({5'd0, sz_rd} == need_r) begin
            waddr          = prev_r;
            next_wdata     = nx_rd;
            next_we        = 1'b1;
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = p_r + 12'd1;
            out_status_nxt = STATUS_OK;
            state_nxt      = ST_IDLE;
          end else begin
            size_wdata = sub_sz;
            size_we    = 1'b1;
            q_nxt      = p_r + sub_sz[ADDR_W-1:0];
            state_nxt  = ST_SPLIT2;
          end
        end else if (p_r == rover_r) begin
          state_nxt = ST_G_START;
        end else if (steps_inc > WALK_LIMIT) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = STATUS_OOM;
          state_nxt      = ST_IDLE;
        end else begin
          prev_nxt  = p_r;
          p_nxt     = nx_rd;
          raddr     = nx_rd;
          steps_nxt = steps_inc;
        end
      end
      ST_SPLIT2: begin
        waddr          = q_r;
        size_wdata     = need_r[SIZE_W-1:0];
        size_we        = 1'b1;
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = q_r + 12'd1;
        out_status_nxt = STATUS_OK;
        state_nxt      = ST_IDLE;
      end
      ST_G_START: begin
        add_nxt   = (need_r > {5'd0, gmin_r}) ? need_r : {5'd0, gmin_r};
        div_nxt   = 18'd1;
        state_nxt = ST_G_DIV;
      end
      ST_G_DIV: begin
        dreq.start = 1'b1;
        state_nxt  = ST_G_WAIT;
      end
      ST_G_WAIT: begin
        if (div_done) begin
          if (grow_ok) begin
            waddr      = brk_r[ADDR_W-1:0];
            next_wdata = '0;
            size_wdata = chunk[SIZE_W-1:0];
            next_we    = 1'b1;
            size_we    = 1'b1;
            b_nxt      = brk_r[ADDR_W-1:0];
            brk_nxt    = brk_sum[SIZE_W-1:0];
            state_nxt  = ST_R_START;
          end else if (chunk >= need_r) begin
            div_nxt   = div_r + 18'd1;
            state_nxt = ST_G_DIV;
          end else begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = STATUS_OOM;
            state_nxt      = ST_IDLE;
          end
        end
      end
      ST_R_START: begin
        raddr     = rover_r;
        p_nxt     = rover_r;
        steps_nxt = '0;
        state_nxt = ST_R_EVAL;
      end
      ST_R_EVAL: begin
        if (brk_hit) begin
          nx_nxt    = nx_rd;
          sp_nxt    = sz_rd;
          raddr     = b_r;
          state_nxt = ST_R_RDB;
        end else if (steps_inc > WALK_LIMIT) begin
          // abandon the insertion
          if (is_alloc_r) begin
            steps_nxt = 13'd1;
            state_nxt = ST_A_START;
          end else begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = STATUS_OK;
            state_nxt      = ST_IDLE;
          end
        end else begin
          p_nxt     = nx_rd;
          raddr     = nx_rd;
          steps_nxt = steps_inc;
        end
      end
      ST_R_RDB: begin
        sb_nxt    = sz_rd;
        raddr     = nx_r;
        state_nxt = ST_R_RDNX;
      end
      ST_R_RDNX: begin
        // merge with the upper neighbor
        if (b_end == {1'b0, nx_r}) begin
          sbn_nxt = sb_r + sz_rd;
          nbn_nxt = nx_rd;
        end else begin
          sbn_nxt = sb_r;
          nbn_nxt = nx_r;
        end
        waddr      = b_r;
        size_wdata = sbn_nxt;
        next_wdata = nbn_nxt;
        size_we    = 1'b1;
        next_we    = 1'b1;
        state_nxt  = ST_R_WP;
      end
      ST_R_WP: begin
        // merge with the lower neighbor
        waddr   = p_r;
        next_we = 1'b1;
        if (p_end == {1'b0, b_r}) begin
          size_wdata = sp_r + sbn_r;
          size_we    = 1'b1;
          next_wdata = nbn_r;
        end else begin
          next_wdata = b_r;
        end
        rover_nxt = p_r;
        if (is_alloc_r) begin
          steps_nxt = 13'd1;
          state_nxt = ST_A_START;
        end else begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      rover_r     <= '0;
      brk_r       <= 13'd1;
      gmin_r      <= GROWTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        gmin_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    is_alloc_r   <= is_alloc_nxt;
    need_r       <= need_nxt;
    p_r          <= p_nxt;
    prev_r       <= prev_nxt;
    b_r          <= b_nxt;
    nx_r         <= nx_nxt;
    q_r          <= q_nxt;
    sp_r         <= sp_nxt;
    sb_r         <= sb_nxt;
    sbn_r        <= sbn_nxt;
    nbn_r        <= nbn_nxt;
    steps_r      <= steps_nxt;
    add_r        <= add_nxt;
    div_r        <= div_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_status_r;

  `FFA_ASSERT(a_start_busy, (start && !busy) |=> (busy || out_valid), "accepted item was dropped")
  `FFA_ASSERT(a_oom_addr, (out_valid && out_status) |-> (out_payload_address == '0),
              "out-of-memory result with nonzero address")
  `FFA_ASSERT(a_brk_range, brk_r <= ARENA_TOP, "break pointer beyond arena")
  `FFA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule

@@ dv/tb_first_fit_free_list_allocator.sv @@
`timescale 1ns / 1ps
module tb_first_fit_free_list_allocator;
  import ffa_pkg::*;

  localparam int unsigned UNITS      = 4096;
  localparam int unsigned WALK_STEPS = UNITS + 1;
  localparam int unsigned CYCLE_CAP  = 20_000_000;
  localparam int unsigned RAND_ITEMS = 1620;

  typedef struct {
    logic               kind;
    logic [BYTES_W-1:0] bytes;
    logic [ADDR_W-1:0]  blk;
  } heap_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              status;
  } heap_resp_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = KIND_ALLOC;
  logic [BYTES_W-1:0] in_size_bytes = '0;
  logic [ADDR_W-1:0]  in_block_address = '0;
  logic               out_valid;
  logic [ADDR_W-1:0]  out_payload_address;
  logic               out_status;
  logic               cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]  cfg_wr_data = '0;

  // Shadow heap state
  int unsigned hdr_link [UNITS];
  int unsigned hdr_units [UNITS];
  int unsigned rover_u;
  int unsigned brk_u;
  int unsigned heap_total;
  int unsigned grow_min;

  heap_req_t   pending_reqs[$];
  heap_resp_t  expected_resps[$];
  int unsigned live_blocks[$];

  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  bit          no_idle = 1'b0;
  int unsigned errors = 0;
  int unsigned n_alloc = 0, n_oom = 0, n_free = 0, n_checked = 0;

  first_fit_free_list_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_size_bytes       (in_size_bytes),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_payload_address (out_payload_address),
    .out_status          (out_status),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic int unsigned rd_link(int unsigned i);
    return (i < UNITS) ? hdr_link[i] : 0;
  endfunction

  function automatic int unsigned rd_units(int unsigned i);
    return (i < UNITS) ? hdr_units[i] : 0;
  endfunction

  function automatic void wr_link(int unsigned i, int unsigned v);
    if (i < UNITS) hdr_link[i] = v;
  endfunction

  function automatic void wr_units(int unsigned i, int unsigned v);
    if (i < UNITS) hdr_units[i] = v;
  endfunction

  // Insert the block headed at unit b by address and merge with neighbors
  function automatic void heap_insert_block(int unsigned b);
    int unsigned p;
    int unsigned nx;
    int unsigned steps;
    p = rover_u;
    steps = 0;
    while (1) begin
      nx = rd_link(p);
      if (p < b && b < nx) break;
      if (p >= nx && (p < b || b < nx)) break;
      p = nx;
      steps++;
      if (steps > WALK_STEPS) return;
    end
    if (b + rd_units(b) == nx) begin
      wr_units(b, rd_units(b) + rd_units(nx));
      wr_link(b, rd_link(nx));
    end else begin
      wr_link(b, nx);
    end
    if (p + rd_units(p) == b) begin
      wr_units(p, rd_units(p) + rd_units(b));
      wr_link(p, rd_link(b));
    end else begin
      wr_link(p, b);
    end
    rover_u = p;
  endfunction

  // First-fit search from the rover, growing the heap when a lap finds nothing
  function automatic void heap_allocate(input int unsigned bytes,
                                        output int unsigned addr, output bit oom);
    int unsigned need;
    int unsigned prev;
    int unsigned p;
    int unsigned steps;
    int unsigned sz;
    int unsigned add;
    int unsigned dv;
    int unsigned chunk;
    int unsigned base;
    bit          ok;
    need = (bytes + 7) / 8 + 1;
    prev = rover_u;
    p = rd_link(prev);
    steps = 0;
    oom = 1'b0;
    addr = 0;
    while (1) begin
      sz = rd_units(p);
      if (sz >= need) begin
        if (sz == need) begin
          wr_link(prev, rd_link(p));
        end else begin
          sz -= need;
          wr_units(p, sz);
          p += sz;
          wr_units(p, need);
        end
        rover_u = prev;
        addr = p + 1;
        return;
      end
      if (p == rover_u) begin
        add = (need > grow_min) ? need : grow_min;
        dv = 1;
        do begin
          chunk = add / dv;
          ok = chunk >= 1 && brk_u + chunk <= UNITS;
          dv++;
        end while (!ok && chunk >= need);
        if (!ok) begin
          oom = 1'b1;
          return;
        end
        base = brk_u;
        brk_u += chunk;
        wr_link(base, 0);
        wr_units(base, chunk);
        heap_insert_block(base);
        heap_total += chunk;
        p = rover_u;
        steps = 0;
      end
      prev = p;
      p = rd_link(p);
      steps++;
      if (steps > WALK_STEPS) begin
        oom = 1'b1;
        return;
      end
    end
  endfunction

  // Work out the result of one accepted transfer
  function automatic void heap_apply(heap_req_t r);
    heap_resp_t  e;
    int unsigned a;
    bit          oom;
    e.addr = '0;
    e.status = STATUS_OK;
    if (r.kind == KIND_ALLOC) begin
      heap_allocate(r.bytes, a, oom);
      e.addr = a[ADDR_W-1:0];
      e.status = oom ? STATUS_OOM : STATUS_OK;
      n_alloc++;
      if (oom) n_oom++;
      else if (e.addr != 0) live_blocks.push_back(e.addr);
    end else begin
      n_free++;
      if (r.blk >= 2 && r.blk - 1 < brk_u) heap_insert_block(r.blk - 1);
    end
    expected_resps.push_back(e);
  endfunction

  // Driver: present queued items, hold until accepted, insert random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) heap_apply('{in_kind, in_size_bytes, in_block_address});
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0 && !no_idle && $urandom_range(0, 99) < 15) begin
        gap_left <= $urandom_range(1, 4) - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        heap_req_t r;
        r = pending_reqs.pop_front();
        in_kind <= r.kind;
        in_size_bytes <= r.bytes;
        in_block_address <= r.blk;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result addr=%0d status=%0d", $time,
                 out_payload_address, out_status);
        errors++;
      end else begin
        heap_resp_t e;
        e = expected_resps.pop_front();
        n_checked++;
        if (out_payload_address !== e.addr) begin
          $display("%0t: payload_address expected %0d actual %0d", $time,
                   e.addr, out_payload_address);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_req(logic kind, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] blk);
    while (pending_reqs.size() >= 2) @(posedge clk);
    pending_reqs.push_back('{kind, bytes, blk});
  endtask

  // Wait, then recheck until nothing is queued or in flight
  task automatic wait_idle();
    do begin
      repeat (4) @(posedge clk);
    end while (pending_reqs.size() > 0 || start || busy || expected_resps.size() > 0);
  endtask

  task automatic write_growth(int unsigned v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[SIZE_W-1:0];
    @(posedge clk);
    grow_min = v & 32'h1FFF;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic free_live();
    int unsigned k;
    k = $urandom_range(0, live_blocks.size() - 1);
    push_req(KIND_FREE, $urandom, live_blocks[k]);
    live_blocks.delete(k);
  endtask

  // One random item: mostly alloc/free of live blocks, some ignored frees
  task automatic random_item();
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    if (live_blocks.size() > 0 && (r < 40 || (live_blocks.size() > 40 && r < 70))) begin
      free_live();
    end else if (r >= 97) begin
      if (r == 99) begin
        wait_idle();
        if (brk_u < UNITS - 1) push_req(KIND_FREE, $urandom, $urandom_range(brk_u + 1, 4095));
        else push_req(KIND_FREE, $urandom, $urandom_range(0, 1));
      end else begin
        push_req(KIND_FREE, $urandom, $urandom_range(0, 1));
      end
    end else begin
      s = $urandom_range(0, 99);
      if (s < 70) push_req(KIND_ALLOC, $urandom_range(0, 64), $urandom);
      else if (s < 90) push_req(KIND_ALLOC, $urandom_range(65, 2000), $urandom);
      else if (s < 97) push_req(KIND_ALLOC, $urandom_range(2001, 40000), $urandom);
      else push_req(KIND_ALLOC, $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned growth_steps[6];
    int unsigned a0, a1, a2;
    for (int i = 0; i < UNITS; i++) begin
      hdr_link[i] = 0;
      hdr_units[i] = 0;
    end
    rover_u = 0;
    brk_u = 1;
    heap_total = 0;
    grow_min = GROWTH_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: size extremes, rounding edges, ignored frees, merges
    no_idle = 1'b1;
    push_req(KIND_ALLOC, 0, 0);
    push_req(KIND_ALLOC, 1, 12'hFFF);
    push_req(KIND_ALLOC, 8, 0);
    push_req(KIND_ALLOC, 9, 0);
    push_req(KIND_ALLOC, 20'hFFFFF, 0);
    push_req(KIND_FREE, 0, 0);
    push_req(KIND_FREE, 20'hFFFFF, 1);
    wait_idle();
    push_req(KIND_FREE, 0, 12'hFFF);
    push_req(KIND_ALLOC, 24, 0);
    push_req(KIND_ALLOC, 24, 0);
    push_req(KIND_ALLOC, 24, 0);
    wait_idle();
    a0 = live_blocks[live_blocks.size() - 3];
    a1 = live_blocks[live_blocks.size() - 2];
    a2 = live_blocks[live_blocks.size() - 1];
    repeat (3) live_blocks.pop_back();
    // free both neighbors first, then the middle so it merges both ways
    push_req(KIND_FREE, 0, a0);
    push_req(KIND_FREE, 0, a2);
    push_req(KIND_FREE, 0, a1);
    push_req(KIND_ALLOC, 8000, 0);
    push_req(KIND_ALLOC, 32000, 0);

    // Minimum growth of one unit, then fill the arena to its top unit
    write_growth(1);
    push_req(KIND_ALLOC, 100, 0);
    wait_idle();
    if (brk_u < UNITS) push_req(KIND_ALLOC, (UNITS - brk_u - 2) * 8, 0);
    push_req(KIND_ALLOC, 0, 0);
    push_req(KIND_ALLOC, 0, 0);
    push_req(KIND_ALLOC, 0, 0);
    while (live_blocks.size() > 0) free_live();
    no_idle = 1'b0;

    // Random phases across growth settings, largest included
    growth_steps = '{4096, 8, $urandom_range(1, 4096), 1, 1024, $urandom_range(1, 64)};
    for (int ph = 0; ph < 6; ph++) begin
      write_growth(growth_steps[ph]);
      no_idle = (ph == 5) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < RAND_ITEMS / 6; i++) random_item();
    end

    // Drain and let any late result show up
    wait_idle();
    repeat (200) @(posedge clk);
    $display("run: %0d allocs (%0d out of memory), %0d frees, %0d results checked",
             n_alloc, n_oom, n_free, n_checked);
    $display("run: growth minimum swept 1..4096, heap reached break unit %0d", brk_u);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_ram.sv
hw/rtl/ffa_div.sv
hw/rtl/first_fit_free_list_allocator.sv
dv/tb_first_fit_free_list_allocator.sv
